// ----- rtl/mot_pkg.sv -----
`timescale 1ns / 1ps
// Package for the map to odometry correction transform.
// Holds number formats, CORDIC constants and saturation helpers; no dependencies.
package mot_pkg;

  // raw angle, reduced angle and CORDIC vector widths (Q.30 radians / Q.30 values)
  localparam int AW = 35;
  localparam int RW = 34;
  localparam int XW = 33;
  localparam int TABLE_LEN = 24;

  localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

  // iterations actually run, and register stages taken by one CORDIC
  function automatic int cordic_iters(input int steps);
    return (steps > TABLE_LEN) ? TABLE_LEN : steps;
  endfunction

  function automatic int cordic_stages(input int steps);
    return cordic_iters(steps) + 4;
  endfunction

  // arctangent of 2^-i in Q.30 radians
  function automatic logic signed [RW-1:0] atan_q30(input int i);
    logic signed [RW-1:0] r;
    unique case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      default: r = 34'sd128;
    endcase
    return r;
  endfunction

  // clamp a translation sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [41:0] v);
    return (v > 42'sd2147483647) || (v < -42'sd2147483648);
  endfunction

  // clamp a rounded quaternion term to Q1.15
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/mot_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for pose pairs in and correction transforms out.
// Stand-alone; no package needed.
interface mot_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] map_x;
  logic signed [31:0] map_y;
  logic signed [19:0] map_yaw;
  logic signed [31:0] odom_x;
  logic signed [31:0] odom_y;
  logic signed [19:0] odom_yaw;

  modport source (output valid, map_x, map_y, map_yaw, odom_x, odom_y, odom_yaw,
                  input ready);
  modport sink   (input valid, map_x, map_y, map_yaw, odom_x, odom_y, odom_yaw,
                  output ready);
endinterface

interface mot_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] corr_x;
  logic signed [31:0] corr_y;
  logic signed [20:0] corr_yaw;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_z;
  logic               overflow;

  modport source (output valid, corr_x, corr_y, corr_yaw, quat_w, quat_z, overflow,
                  input ready);
  modport sink   (input valid, corr_x, corr_y, corr_yaw, quat_w, quat_z, overflow,
                  output ready);
endinterface

// ----- rtl/mot_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: angle reduction, quadrant fold, one stage per step.
// Depends on mot_pkg; stage enables come from the owner's pipeline control.
module mot_cordic
  import mot_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic [cordic_stages(CORDIC_STEPS)-1:0] en_i,
  input  logic signed [AW-1:0] angle_i,
  output logic signed [XW-1:0] cos_o,
  output logic signed [XW-1:0] sin_o
);

  localparam int NIT = cordic_iters(CORDIC_STEPS);
  localparam int CS  = cordic_stages(CORDIC_STEPS);

  logic signed [AW-1:0] a0_q, a1_q, a1_d;
  logic signed [RW-1:0] a_q [NIT+1];
  logic signed [XW-1:0] x_q [NIT+1];
  logic signed [XW-1:0] y_q [NIT+1];
  logic                 neg_q [NIT+1];
  logic signed [RW-1:0] af_d;
  logic                 negf_d;
  logic signed [XW-1:0] cos_q, sin_q;

  // capture the raw angle
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a0_q <= angle_i;
    end
  end

  // bring the angle into [-pi, pi]
  always_comb begin
    if (a0_q > PI_Q30) begin
      a1_d = a0_q - TWO_PI_Q30;
    end else if (a0_q < -PI_Q30) begin
      a1_d = a0_q + TWO_PI_Q30;
    end else begin
      a1_d = a0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a1_q <= a1_d;
    end
  end

  // fold into [-pi/2, pi/2], remember to negate the result
  always_comb begin
    priority if (a1_q > HALF_PI_Q30) begin
      af_d   = RW'(a1_q - PI_Q30);
      negf_d = 1'b1;
    end else if (a1_q < -HALF_PI_Q30) begin
      af_d   = RW'(a1_q + PI_Q30);
      negf_d = 1'b1;
    end else begin
      af_d   = RW'(a1_q);
      negf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      a_q[0]   <= af_d;
      x_q[0]   <= GAIN_Q30;
      y_q[0]   <= '0;
      neg_q[0] <= negf_d;
    end
  end

  // one micro-rotation per stage
  for (genvar j = 0; j < NIT; j++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i[3+j]) begin
        if (a_q[j] >= 0) begin
          x_q[j+1] <= x_q[j] - (y_q[j] >>> j);
          y_q[j+1] <= y_q[j] + (x_q[j] >>> j);
          a_q[j+1] <= a_q[j] - atan_q30(j);
        end else begin
          x_q[j+1] <= x_q[j] + (y_q[j] >>> j);
          y_q[j+1] <= y_q[j] - (x_q[j] >>> j);
          a_q[j+1] <= a_q[j] + atan_q30(j);
        end
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i[CS-1]) begin
      cos_q <= neg_q[NIT] ? -x_q[NIT] : x_q[NIT];
      sin_q <= neg_q[NIT] ? -y_q[NIT] : y_q[NIT];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ----- rtl/map_odom_correction_transform.sv -----
`timescale 1ns / 1ps
// Top level: correction transform T_map * inverse(T_odom) for planar poses.
// Depends on mot_pkg, mot_if and mot_cordic.
//
//  port    dir  beat contents
//  in_i    in   map x/y/yaw and odom x/y/yaw
//  out_o   out  corr x/y/yaw, quat w/z, overflow flag
//
// One beat accepted per cycle while the output is not stalled; three CORDIC
// pipelines of CORDIC_STEPS + 4 stages side by side, then four stages of
// multiply and accumulate. Reset clears the stage valid bits only.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and a stall at the output drops or repeats nothing.
module map_odom_correction_transform
  import mot_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mot_in_if.sink    in_i,
  mot_out_if.source out_o
);

  localparam int CS  = cordic_stages(CORDIC_STEPS);
  localparam int KM1 = CS;
  localparam int KM2 = CS + 1;
  localparam int KM3 = CS + 2;
  localparam int KM4 = CS + 3;
  localparam int NST = CS + 4;

  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [20:0] dyaw;
  } side_t;

  logic [NST-1:0] v_q, v_d, en;
  side_t          side_q [CS];
  side_t          side_in;

  logic signed [AW-1:0] ang_m, ang_o, ang_h;
  logic signed [XW-1:0] cm, sm, co, so, ch, sh;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NST-1] = ~v_q[NST-1] | out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = en[0];

  // angles in Q.30; the half-angle path takes corr_yaw / 2
  assign side_in.mx   = in_i.map_x;
  assign side_in.my   = in_i.map_y;
  assign side_in.ox   = in_i.odom_x;
  assign side_in.oy   = in_i.odom_y;
  assign side_in.dyaw = 21'(in_i.map_yaw) - 21'(in_i.odom_yaw);
  assign ang_m = AW'(in_i.map_yaw) <<< 14;
  assign ang_o = AW'(in_i.odom_yaw) <<< 14;
  assign ang_h = AW'(side_in.dyaw) <<< 13;

  mot_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_map (
    .clk_i, .en_i(en[CS-1:0]), .angle_i(ang_m), .cos_o(cm), .sin_o(sm)
  );
  mot_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_odom (
    .clk_i, .en_i(en[CS-1:0]), .angle_i(ang_o), .cos_o(co), .sin_o(so)
  );
  mot_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_half (
    .clk_i, .en_i(en[CS-1:0]), .angle_i(ang_h), .cos_o(ch), .sin_o(sh)
  );

  // carry positions and yaw difference alongside the CORDICs
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_in;
    end
  end

  for (genvar k = 1; k < CS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage M1: odometry rotation products, quaternion rounding
  logic signed [64:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  logic signed [XW-1:0] cm1_q, sm1_q;
  logic signed [31:0] mx1_q, my1_q;
  logic signed [20:0] dyaw1_q;
  logic signed [15:0] qw1_q, qz1_q;
  logic signed [XW-1:0] ch_r, sh_r;

  assign ch_r = ch + XW'(16384);
  assign sh_r = sh + XW'(16384);

  always_ff @(posedge clk_i) begin
    if (en[KM1]) begin
      p_cx_q  <= co * side_q[CS-1].ox;
      p_sy_q  <= so * side_q[CS-1].oy;
      p_cy_q  <= co * side_q[CS-1].oy;
      p_sx_q  <= so * side_q[CS-1].ox;
      cm1_q   <= cm;
      sm1_q   <= sm;
      mx1_q   <= side_q[CS-1].mx;
      my1_q   <= side_q[CS-1].my;
      dyaw1_q <= side_q[CS-1].dyaw;
      qw1_q   <= sat16(18'(ch_r >>> 15));
      qz1_q   <= sat16(18'(sh_r >>> 15));
    end
  end

  // stage M2: inverse odometry translation, rounded and negated
  // (a rotated Q16.16 vector stays within 33 signed bits, 34 leave headroom)
  logic signed [65:0] sx_d, sy_d;
  logic signed [33:0] ix_q, iy_q;
  logic signed [XW-1:0] cm2_q, sm2_q;
  logic signed [31:0] mx2_q, my2_q;
  logic signed [20:0] dyaw2_q;
  logic signed [15:0] qw2_q, qz2_q;

  assign sx_d = 66'(p_cx_q) + 66'(p_sy_q) + 66'sd536870912;
  assign sy_d = 66'(p_cy_q) - 66'(p_sx_q) + 66'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en[KM2]) begin
      ix_q    <= -34'(sx_d >>> 30);
      iy_q    <= -34'(sy_d >>> 30);
      cm2_q   <= cm1_q;
      sm2_q   <= sm1_q;
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      dyaw2_q <= dyaw1_q;
      qw2_q   <= qw1_q;
      qz2_q   <= qz1_q;
    end
  end

  // stage M3: map rotation products
  logic signed [66:0] q1_q, q2_q, q3_q, q4_q;
  logic signed [31:0] mx3_q, my3_q;
  logic signed [20:0] dyaw3_q;
  logic signed [15:0] qw3_q, qz3_q;

  always_ff @(posedge clk_i) begin
    if (en[KM3]) begin
      q1_q    <= cm2_q * ix_q;
      q2_q    <= sm2_q * iy_q;
      q3_q    <= sm2_q * ix_q;
      q4_q    <= cm2_q * iy_q;
      mx3_q   <= mx2_q;
      my3_q   <= my2_q;
      dyaw3_q <= dyaw2_q;
      qw3_q   <= qw2_q;
      qz3_q   <= qz2_q;
    end
  end

  // stage M4: round, add map translation, saturate into the output register
  logic signed [67:0] rx_d, ry_d;
  logic signed [41:0] tx_d, ty_d;
  logic signed [31:0] corr_x_q, corr_y_q;
  logic signed [20:0] corr_yaw_q;
  logic signed [15:0] quat_w_q, quat_z_q;
  logic               overflow_q;

  assign rx_d = 68'(q1_q) - 68'(q2_q) + 68'sd536870912;
  assign ry_d = 68'(q3_q) + 68'(q4_q) + 68'sd536870912;
  assign tx_d = 42'(mx3_q) + 42'(rx_d >>> 30);
  assign ty_d = 42'(my3_q) + 42'(ry_d >>> 30);

  always_ff @(posedge clk_i) begin
    if (en[KM4]) begin
      corr_x_q   <= sat32(tx_d);
      corr_y_q   <= sat32(ty_d);
      overflow_q <= ovf32(tx_d) | ovf32(ty_d);
      corr_yaw_q <= dyaw3_q;
      quat_w_q   <= qw3_q;
      quat_z_q   <= qz3_q;
    end
  end

  assign out_o.valid    = v_q[NST-1];
  assign out_o.corr_x   = corr_x_q;
  assign out_o.corr_y   = corr_y_q;
  assign out_o.corr_yaw = corr_yaw_q;
  assign out_o.quat_w   = quat_w_q;
  assign out_o.quat_z   = quat_z_q;
  assign out_o.overflow = overflow_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for map_odom_correction_transform: pose pairs in, correction
// transforms out, each compared against an in-bench fixed-point model.
// Depends on mot_pkg, mot_if and the RTL of the block.
module testbench;
  import mot_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 8;
  localparam longint CYCLE_LIMIT = 200000;
  localparam longint PI_L = 64'sd3373259426;
  localparam longint HPI_L = 64'sd1686629713;
  localparam longint TWO_PI_L = 64'sd6746518852;
  localparam longint GAIN_L = 64'sd652032874;

  typedef struct packed {
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic signed [19:0] map_yaw;
    logic signed [31:0] odom_x;
    logic signed [31:0] odom_y;
    logic signed [19:0] odom_yaw;
  } pose_pair_t;

  typedef struct packed {
    logic signed [31:0] corr_x;
    logic signed [31:0] corr_y;
    logic signed [20:0] corr_yaw;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic               overflow;
  } correction_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mot_in_if  pose_ch ();
  mot_out_if corr_ch ();

  map_odom_correction_transform #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pose_ch.sink),
    .out_o  (corr_ch.source)
  );

  always #6 clk_i = ~clk_i;

  correction_t pending_corrections[$];
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_saturated = 0;
  longint cycle_count = 0;
  bit     sink_idle_enable = 1'b1;
  bit     src_idle_enable = 1'b1;
  int     sink_hold = 0;

  // arithmetic shift right as floor division
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                        128};
    return tab[i];
  endfunction

  // rotation-mode CORDIC with quadrant folding, Q.30 in and out
  function automatic void cordic_sincos(input longint ang, output longint c,
                                        output longint s);
    longint x, y, nx, a;
    bit     flip;
    int     iters;
    x = GAIN_L;
    y = 0;
    a = ang;
    flip = 1'b0;
    iters = (STEPS > 24) ? 24 : STEPS;
    for (int k = 0; k < 4 && a > PI_L; k++) a -= TWO_PI_L;
    for (int k = 0; k < 4 && a < -PI_L; k++) a += TWO_PI_L;
    if (a > HPI_L) begin
      a -= PI_L;
      flip = 1'b1;
    end else if (a < -HPI_L) begin
      a += PI_L;
      flip = 1'b1;
    end
    for (int i = 0; i < iters; i++) begin
      if (a >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        a -= atan_entry(i);
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        a += atan_entry(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, ref bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // correction = map pose composed with inverse odometry pose
  function automatic correction_t predict_correction(pose_pair_t p);
    correction_t r;
    longint cm, sm, co, so, ch, sh, ix, iy, tx, ty, dyaw;
    bit ovf, unused;
    ovf = 1'b0;
    unused = 1'b0;
    cordic_sincos(longint'(p.map_yaw) <<< 14, cm, sm);
    cordic_sincos(longint'(p.odom_yaw) <<< 14, co, so);
    ix = -round_half_up(co * p.odom_x + so * p.odom_y, 30);
    iy = -round_half_up(co * p.odom_y - so * p.odom_x, 30);
    tx = longint'(p.map_x) + round_half_up(cm * ix - sm * iy, 30);
    ty = longint'(p.map_y) + round_half_up(sm * ix + cm * iy, 30);
    tx = clamp(tx, -64'sd2147483648, 64'sd2147483647, ovf);
    ty = clamp(ty, -64'sd2147483648, 64'sd2147483647, ovf);
    dyaw = longint'(p.map_yaw) - longint'(p.odom_yaw);
    cordic_sincos(dyaw <<< 13, ch, sh);
    r.corr_x   = tx[31:0];
    r.corr_y   = ty[31:0];
    r.corr_yaw = dyaw[20:0];
    r.quat_w   = 16'(clamp(round_half_up(ch, 15), -32768, 32767, unused));
    r.quat_z   = 16'(clamp(round_half_up(sh, 15), -32768, 32767, unused));
    r.overflow = ovf;
    return r;
  endfunction

  // drive one beat and queue its expected correction
  task automatic send_pose_pair(input pose_pair_t p);
    int gap;
    if (src_idle_enable && $urandom_range(0, 5) == 0) begin
      pose_ch.valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk_i);
    end
    pose_ch.valid    <= 1'b1;
    pose_ch.map_x    <= p.map_x;
    pose_ch.map_y    <= p.map_y;
    pose_ch.map_yaw  <= p.map_yaw;
    pose_ch.odom_x   <= p.odom_x;
    pose_ch.odom_y   <= p.odom_y;
    pose_ch.odom_yaw <= p.odom_yaw;
    do @(posedge clk_i); while (!pose_ch.ready);
    pending_corrections.push_back(predict_correction(p));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic finish_sending();
    pose_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_corrections.size() != 0) @(negedge clk_i);
  endtask

  function automatic pose_pair_t random_pose_pair();
    pose_pair_t p;
    p.map_x = $urandom();
    p.map_y = $urandom();
    p.map_yaw = 20'($urandom());
    p.odom_x = $urandom();
    p.odom_y = $urandom();
    p.odom_yaw = 20'($urandom());
    // mostly realistic magnitudes, keeping full-range extremes in the mix
    if ($urandom_range(0, 3) != 0) begin
      p.map_x  = $signed(p.map_x) >>> $urandom_range(0, 20);
      p.map_y  = $signed(p.map_y) >>> $urandom_range(0, 20);
      p.odom_x = $signed(p.odom_x) >>> $urandom_range(0, 20);
      p.odom_y = $signed(p.odom_y) >>> $urandom_range(0, 20);
    end
    return p;
  endfunction

  function automatic pose_pair_t make_pair(longint mx, longint my, longint myaw,
                                           longint ox, longint oy, longint oyaw);
    pose_pair_t p;
    p.map_x = mx[31:0];
    p.map_y = my[31:0];
    p.map_yaw = myaw[19:0];
    p.odom_x = ox[31:0];
    p.odom_y = oy[31:0];
    p.odom_yaw = oyaw[19:0];
    return p;
  endfunction

  // extremes, saturation, quadrant folds and the unwrapped yaw difference
  task automatic test_directed();
    longint maxp = 64'sd2147483647;
    longint minp = -64'sd2147483648;
    send_pose_pair(make_pair(0, 0, 0, 0, 0, 0));
    send_pose_pair(make_pair(maxp, maxp, 524287, maxp, maxp, -524288));
    send_pose_pair(make_pair(minp, minp, -524288, minp, minp, 524287));
    send_pose_pair(make_pair(maxp, 0, 0, minp, 0, 0));
    send_pose_pair(make_pair(minp, 0, 0, maxp, 0, 0));
    send_pose_pair(make_pair(0, maxp, 0, 0, minp, 0));
    send_pose_pair(make_pair(65536, 131072, 102944, 65536, 0, 0));
    send_pose_pair(make_pair(0, 0, 205887, 0, 0, -205887));
    send_pose_pair(make_pair(0, 0, -205887, 0, 0, 205887));
    send_pose_pair(make_pair(0, 0, 102943, 0, 0, 0));
    send_pose_pair(make_pair(0, 0, 102945, 0, 0, 0));
    send_pose_pair(make_pair(0, 0, -102945, 0, 0, 0));
    send_pose_pair(make_pair(0, 0, 411775, 0, 0, -411775));
    send_pose_pair(make_pair(100 << 16, -50 << 16, 30000, 20 << 16, 7 << 16, -40000));
    send_pose_pair(make_pair(-1, -1, -1, -1, -1, -1));
    send_pose_pair(make_pair(1, 1, 1, 1, 1, 1));
    send_pose_pair(make_pair(0, 0, 0, 0, 0, 411775));
    finish_sending();
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_pose_pair(random_pose_pair());
    finish_sending();
  endtask

  // stall the output long enough to fill the pipeline and block the input
  task automatic test_backpressure();
    sink_hold = 200;
    src_idle_enable = 1'b0;
    for (int i = 0; i < 80; i++) send_pose_pair(random_pose_pair());
    finish_sending();
    wait_drained();
    src_idle_enable = 1'b1;
  endtask

  task automatic test_streaming(input int count);
    src_idle_enable = 1'b0;
    sink_idle_enable = 1'b0;
    for (int i = 0; i < count; i++) send_pose_pair(random_pose_pair());
    finish_sending();
  endtask

  // output ready: random bursts of stall, plus the long hold on request
  initial begin
    int burst;
    corr_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        corr_ch.ready <= 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end else if (sink_idle_enable && $urandom_range(0, 6) == 0) begin
        corr_ch.ready <= 1'b0;
        burst = $urandom_range(1, 15);
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        corr_ch.ready <= 1'b1;
      end
    end
  end

  // compare each accepted beat with the oldest prediction
  always @(posedge clk_i) begin
    correction_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && corr_ch.valid && corr_ch.ready) begin
      if (pending_corrections.size() == 0) begin
        $error("unexpected correction beat: corr_x %0d", corr_ch.corr_x);
        n_errors++;
      end else begin
        want = pending_corrections.pop_front();
        n_checked++;
        if (want.overflow) n_saturated++;
        if (corr_ch.corr_x !== want.corr_x) begin
          $error("corr_x expected %0d got %0d", want.corr_x, corr_ch.corr_x);
          n_errors++;
        end
        if (corr_ch.corr_y !== want.corr_y) begin
          $error("corr_y expected %0d got %0d", want.corr_y, corr_ch.corr_y);
          n_errors++;
        end
        if (corr_ch.corr_yaw !== want.corr_yaw) begin
          $error("corr_yaw expected %0d got %0d", want.corr_yaw, corr_ch.corr_yaw);
          n_errors++;
        end
        if (corr_ch.quat_w !== want.quat_w) begin
          $error("quat_w expected %0d got %0d", want.quat_w, corr_ch.quat_w);
          n_errors++;
        end
        if (corr_ch.quat_z !== want.quat_z) begin
          $error("quat_z expected %0d got %0d", want.quat_z, corr_ch.quat_z);
          n_errors++;
        end
        if (corr_ch.overflow !== want.overflow) begin
          $error("overflow expected %0d got %0d", want.overflow, corr_ch.overflow);
          n_errors++;
        end
      end
    end
  end

  // guard against a hung pipeline
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_corrections.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    pose_ch.valid = 1'b0;
    pose_ch.map_x = '0;
    pose_ch.map_y = '0;
    pose_ch.map_yaw = '0;
    pose_ch.odom_x = '0;
    pose_ch.odom_y = '0;
    pose_ch.odom_yaw = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(300);
    test_backpressure();
    test_streaming(150);
    wait_drained();
    repeat (LATENCY + 4) @(negedge clk_i);

    $display("covered %0d pose pairs, %0d results checked, %0d with saturated translation",
             n_sent, n_checked, n_saturated);
    if (n_errors == 0 && pending_corrections.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
